### sv/patu_pkg.sv
// shared constants, codes and types of the paged address translation unit
package patu_pkg;

    // page and table geometry
    localparam int PAGE_BITS     = 10;
    localparam int TBL_IDX_W     = 13;
    localparam int TABLE_ENTRIES = 1 << TBL_IDX_W;
    localparam int ENTRY_W       = 16;
    localparam int FRAME_W       = 13;
    localparam int WIN_IDX_W     = 13;
    localparam int PHYS_W        = 25;

    // access codes
    localparam logic [1:0] OP_FETCH = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // target region codes
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_ROM     = 3'd1;
    localparam logic [2:0] TGT_LOW_RAM = 3'd2;
    localparam logic [2:0] TGT_TABLE   = 3'd3;
    localparam logic [2:0] TGT_MAIN    = 3'd4;
    localparam logic [2:0] TGT_ISTACK  = 3'd5;
    localparam logic [2:0] TGT_EXT     = 3'd6;

    // fault codes
    localparam logic [1:0] FLT_NONE  = 2'd0;
    localparam logic [1:0] FLT_FETCH = 2'd1;
    localparam logic [1:0] FLT_READ  = 2'd2;
    localparam logic [1:0] FLT_WRITE = 2'd3;

    // page entry permission bits
    localparam int PERM_X = 13;
    localparam int PERM_W = 14;
    localparam int PERM_R = 15;

    // result of one access
    typedef struct packed {
        logic [2:0]  target;
        logic [17:0] offset;
        logic [1:0]  fault;
        logic [7:0]  table_byte;
    } patu_result_t;

    // table update request
    typedef struct packed {
        logic                 en;
        logic [TBL_IDX_W-1:0] idx;
        logic [ENTRY_W-1:0]   data;
    } patu_tbl_wr_t;

    // table entry touched by an access: page entry or window entry
    function automatic logic [TBL_IDX_W-1:0] tbl_index(input logic [23:0] address,
                                                        input logic translated_mode);
        logic [23:0]          page;
        logic [WIN_IDX_W-1:0] win;
        logic [TBL_IDX_W-1:0] idx;
        page = address >> PAGE_BITS;
        win  = address[13:1];
        if (translated_mode)
            idx = page[TBL_IDX_W-1:0];
        else
            idx = win[TBL_IDX_W-1:0];
        return idx;
    endfunction

endpackage

### sv/paged_address_translation_unit.sv
// top level of the paged address translation unit: table, pipeline and clear pass
//
// One access beat enters on the input channel (op, address, write_data,
// supervisor, translated_mode) and one result beat leaves on the output
// channel (target, offset, fault, table_byte), both valid/ready.
// An accepted access reads its page or window entry from the table ram at
// the accept edge into the decode stage, which decodes it and loads the
// output register when that register is empty or its beat is being taken.
// Throughput is one access per cycle while the receiver does not stall, set by
// the single table read port and the single decode stage; a table write is
// merged with the read entry and forwarded to the access accepted behind it
// if that reads the same entry. After reset the table is cleared one entry
// per cycle, 8192 entries with the default geometry (TABLE_ENTRIES), and
// in_ready stays low until that is done. When the receiver stalls, the result
// waits in the output register, one more access may wait in the decode stage,
// and in_ready then drops until the output beat is taken.
module paged_address_translation_unit import patu_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [23:0] address,
    input  logic [7:0]  write_data,
    input  logic        supervisor,
    input  logic        translated_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  target,
    output logic [17:0] offset,
    output logic [1:0]  fault,
    output logic [7:0]  table_byte
);

    logic                 clr_busy_reg, clr_busy_next;
    logic [TBL_IDX_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic [1:0]           s1_op_reg;
    logic [23:0]          s1_address_reg;
    logic [7:0]           s1_write_data_reg;
    logic                 s1_supervisor_reg;
    logic                 s1_translated_reg;
    logic                 fwd_hit_reg, fwd_hit_next;
    logic [ENTRY_W-1:0]   fwd_data_reg;
    logic                 out_valid_reg, out_valid_next;
    patu_result_t         out_reg;

    logic                 in_accept;
    logic                 s1_advance;
    logic [TBL_IDX_W-1:0] rd_idx;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [ENTRY_W-1:0]   entry;
    patu_result_t         result;
    patu_tbl_wr_t         xl_wr;
    logic                 s1_wr_en;
    logic                 ram_wr_en;
    logic [TBL_IDX_W-1:0] ram_wr_addr;
    logic [ENTRY_W-1:0]   ram_wr_data;

    // handshake
    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !clr_busy_reg && (!s1_valid_reg || s1_advance);
    assign in_accept  = in_valid && in_ready;
    assign rd_idx     = tbl_index(address, translated_mode);

    // table write: clear pass or a window write leaving the decode stage
    assign s1_wr_en    = xl_wr.en && s1_valid_reg && s1_advance;
    assign ram_wr_en   = clr_busy_reg || s1_wr_en;
    assign ram_wr_addr = clr_busy_reg ? clr_cnt_reg : xl_wr.idx;
    assign ram_wr_data = clr_busy_reg ? '0 : xl_wr.data;

    patu_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (in_accept),
        .rd_addr (rd_idx),
        .rd_data (ram_rdata)
    );

    // entry as seen after the write of the access ahead
    assign entry = fwd_hit_reg ? fwd_data_reg : ram_rdata;

    patu_xlate u_xlate (
        .op              (s1_op_reg),
        .address         (s1_address_reg),
        .write_data      (s1_write_data_reg),
        .supervisor      (s1_supervisor_reg),
        .translated_mode (s1_translated_reg),
        .entry           (entry),
        .result          (result),
        .tbl_wr          (xl_wr)
    );

    // next-state logic
    always_comb
    begin
        clr_busy_next  = clr_busy_reg;
        clr_cnt_next   = clr_cnt_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == TBL_IDX_W'(TABLE_ENTRIES - 1))
                clr_busy_next = 1'b0;
        end
        s1_valid_next  = in_accept || (s1_valid_reg && !s1_advance);
        out_valid_next = s1_advance || (out_valid_reg && !out_ready);
        fwd_hit_next   = fwd_hit_reg;
        if (in_accept)
            fwd_hit_next = s1_wr_en && (xl_wr.idx == rd_idx);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_hit_reg   <= 1'b0;
        end
        else
        begin
            clr_busy_reg  <= clr_busy_next;
            clr_cnt_reg   <= clr_cnt_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg         <= op;
            s1_address_reg    <= address;
            s1_write_data_reg <= write_data;
            s1_supervisor_reg <= supervisor;
            s1_translated_reg <= translated_mode;
            fwd_data_reg      <= xl_wr.data;
        end
        if (s1_advance)
        begin
            out_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign target     = out_reg.target;
    assign offset     = out_reg.offset;
    assign fault      = out_reg.fault;
    assign table_byte = out_reg.table_byte;

`ifndef SYNTH
    // a faulting result carries no region, offset or table byte
    a_fault_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault != FLT_NONE) |->
            (target == TGT_NONE && offset == 18'd0 && table_byte == 8'd0))
        else $error("faulting result carries data");

    // every result without a fault names a region
    a_target_set: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && fault == FLT_NONE) |-> (target != TGT_NONE))
        else $error("result without fault has no target");

    // no access enters or writes the table during the clear pass
    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> (!in_ready && !s1_valid_reg && !s1_wr_en))
        else $error("access during table clear");

    // an accepted beat reaches the decode stage in the next cycle
    a_accept_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted beat lost");

    // a decoded access always lands in the output register
    a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid)
        else $error("decoded access lost");
`endif

endmodule

### sv/patu_ram.sv
// generic single-write, single-read ram with registered read data
module patu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/patu_xlate.sv
// permission check, region decode and table update of one access
module patu_xlate import patu_pkg::*; (
    input  logic [1:0]         op,
    input  logic [23:0]        address,
    input  logic [7:0]         write_data,
    input  logic               supervisor,
    input  logic               translated_mode,
    input  logic [ENTRY_W-1:0] entry,
    output patu_result_t       result,
    output patu_tbl_wr_t       tbl_wr
);

    typedef struct packed {
        logic        ok;
        logic [2:0]  tgt;
        logic [17:0] off;
    } phys_t;

    // physical map: main ram, interrupt stack, extended ram
    function automatic phys_t phys_decode(input logic [PHYS_W-1:0] p);
        phys_t r;
        logic [PHYS_W-1:0] d;
        r = '0;
        d = '0;
        if (p < PHYS_W'(32'h10000))
        begin
            r.ok = 1'b1;
            r.tgt = TGT_MAIN;
            d = p;
        end
        else if (p < PHYS_W'(32'h20000))
        begin
            r.ok = 1'b1;
            r.tgt = TGT_ISTACK;
            d = p - PHYS_W'(32'h10000);
        end
        else if (p <= PHYS_W'(32'h05ffff))
        begin
            r.ok = 1'b1;
            r.tgt = TGT_EXT;
            d = p - PHYS_W'(32'h20000);
        end
        r.off = d[17:0];
        return r;
    endfunction

    logic                   is_fetch;
    logic                   is_write;
    logic [1:0]             deny;
    logic                   permitted;
    logic [PHYS_W-1:0]      virt_phys;
    logic [PHYS_W-1:0]      untr_phys;
    phys_t                  pd;
    logic [WIN_IDX_W-1:0]   win_idx;
    logic                   win_hit;
    logic [2:0]             tgt;
    logic [17:0]            off;
    logic [1:0]             flt;
    logic [7:0]             tb;

    assign is_fetch = (op == OP_FETCH);
    assign is_write = (op == OP_WRITE);
    assign deny     = is_fetch ? FLT_FETCH : (is_write ? FLT_WRITE : FLT_READ);

    // permission bit of the page entry for this access
    assign permitted = is_fetch ? entry[PERM_X] : (is_write ? entry[PERM_W] : entry[PERM_R]);

    assign virt_phys = PHYS_W'({entry[FRAME_W-1:0], address[PAGE_BITS-1:0]});
    assign untr_phys = PHYS_W'(address);
    assign pd        = phys_decode(translated_mode ? virt_phys : untr_phys);

    assign win_idx = address[13:1];
    assign win_hit = ({1'b0, win_idx} < (WIN_IDX_W + 1)'(TABLE_ENTRIES));

    // region decode
    always_comb
    begin
        tgt = TGT_NONE;
        off = '0;
        flt = FLT_NONE;
        tb  = '0;
        tbl_wr.en   = 1'b0;
        tbl_wr.idx  = tbl_index(address, translated_mode);
        tbl_wr.data = address[0] ? {write_data, entry[7:0]} : {entry[15:8], write_data};
        if (!translated_mode)
        begin
            if (!supervisor)
            begin
                flt = deny;
            end
            else if (address[23:16] == 8'h00)
            begin
                if (!address[15])
                begin
                    // rom, read only
                    if (is_write)
                    begin
                        flt = FLT_READ;
                    end
                    else
                    begin
                        tgt = TGT_ROM;
                        off = 18'(address[14:0]);
                    end
                end
                else if (!address[14])
                begin
                    tgt = TGT_LOW_RAM;
                    off = 18'(address[13:0]);
                end
                else
                begin
                    // page table window
                    tgt = TGT_TABLE;
                    off = 18'(address[13:0]);
                    if (win_hit)
                    begin
                        if (is_write)
                            tbl_wr.en = 1'b1;
                        else
                            tb = address[0] ? entry[15:8] : entry[7:0];
                    end
                end
            end
            else if (pd.ok)
            begin
                tgt = pd.tgt;
                off = pd.off;
            end
            else
            begin
                flt = FLT_READ;
            end
        end
        else
        begin
            if (!permitted && !supervisor)
            begin
                flt = deny;
            end
            else if (pd.ok)
            begin
                tgt = pd.tgt;
                off = pd.off;
            end
            else
            begin
                flt = FLT_READ;
            end
        end
        // a fault reports nothing else
        if (flt != FLT_NONE)
        begin
            tgt = TGT_NONE;
            off = '0;
            tb  = '0;
        end
    end

    assign result.target     = tgt;
    assign result.offset     = off;
    assign result.fault      = flt;
    assign result.table_byte = tb;

endmodule
